FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Every check is clocked on
// i_clk and is disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next-cycle check");

`endif

FILE: sv/hrld_pkg.sv
// ----------------------------------------------------------------------------
// hrld_pkg
// Types and constants for the HTTP response length deframer: result kinds,
// the header line scan phases, and the header name to be matched.
// ----------------------------------------------------------------------------
package hrld_pkg;

    // Result kinds
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_STORED   = 3'd1;
    localparam logic [2:0] KIND_DROPPED  = 3'd2;
    localparam logic [2:0] KIND_OVERFLOW = 3'd3;
    localparam logic [2:0] KIND_BAD_LEN  = 3'd4;
    localparam logic [2:0] KIND_IGNORED  = 3'd5;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;

    // Last three header bytes when the terminator is one LF away
    localparam logic [23:0] TERM_PREFIX = 24'h0D0A0D;

    // Header name, lower case
    localparam int unsigned NAME_LEN = 14;
    localparam int unsigned KEY_W    = 4;

    // Reset value of the max_length register
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd1048576;

    // Version word sits at body offsets four to seven
    localparam logic [31:0] VER_FIRST = 32'd4;
    localparam logic [31:0] VER_LAST  = 32'd7;
    localparam logic [31:0] VER_DONE  = 32'd8;

    // Scan phase within one header line
    typedef enum logic [3:0] {
        PH_KEY   = 4'b0001,
        PH_BLANK = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_REST  = 4'b1000
    } t_line_phase;

    // Character of "content-length" at a given position
    function automatic logic [7:0] name_char(input logic [KEY_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: sv/http_response_length_deframer_unit.sv
// ----------------------------------------------------------------------------
// http_response_length_deframer_unit
// Takes an HTTP response one byte per transaction and gives one result per
// byte. Header bytes are counted (at most HEADER_MAX) until CR LF CR LF;
// the first "content-length:" line (name in any case) supplies the body
// length, which must be nonzero and no larger than max_length. Body bytes
// come out with their offset up to that length and are dropped after it;
// body bytes four to seven form the little-endian package version. After
// any error every byte is reported as ignored until reset. Throughput is
// one byte per clock while the result port is not stalled: each byte passes
// an input register, the scan logic (the longest path is the saturating
// multiply-by-ten of the length value) and a result register. max_length
// resets to 1048576 and is written on the configuration channel; the user
// must write it only while no byte is in flight, the block does not enforce it.
// ----------------------------------------------------------------------------
module http_response_length_deframer_unit #(
    parameter int HEADER_MAX = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_body_byte,
    output logic [31:0] o_body_offset,
    output logic [31:0] o_content_length,
    output logic [31:0] o_package_version,
    output logic        o_version_valid,
    output logic        o_complete,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int CntW = $clog2(HEADER_MAX + 1);

    // Pipeline control
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       out_free;
    logic       advance;
    logic       in_accept;

    // Block state
    logic [31:0]                 r_max_length;
    logic [23:0]                 r_recent,     n_recent;
    logic [CntW-1:0]             r_hdr_count,  n_hdr_count;
    logic [hrld_pkg::KEY_W-1:0]  r_key_pos,    n_key_pos;
    hrld_pkg::t_line_phase       r_phase,      n_phase;
    logic [31:0]                 r_accum,      n_accum;
    logic                        r_found,      n_found;
    logic                        r_header_done, n_header_done;
    logic [31:0]                 r_length_reg, n_length_reg;
    logic [31:0]                 r_offset,     n_offset;
    logic [31:0]                 r_version,    n_version;
    logic                        r_error,      n_error;

    // Result registers
    logic [2:0]  r_out_kind,    n_out_kind;
    logic [7:0]  r_out_byte,    n_out_byte;
    logic [31:0] r_out_offset,  n_out_offset;
    logic [31:0] r_out_length,  n_out_length;
    logic [31:0] r_out_version, n_out_version;
    logic        r_out_vvalid,  n_out_vvalid;
    logic        r_out_complete, n_out_complete;

    // Scan helpers
    logic [7:0]  b;
    logic [7:0]  lc;
    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] mul10;
    logic [31:0] len_val;
    logic [1:0]  ver_lane;

    // Handshake
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Byte decode
    assign b        = r_in_byte;
    assign lc       = (b >= hrld_pkg::CH_UC_A && b <= hrld_pkg::CH_UC_Z) ? b + 8'd32 : b;
    assign is_digit = (b >= hrld_pkg::CH_ZERO && b <= hrld_pkg::CH_NINE);
    assign digit    = 4'(b - hrld_pkg::CH_ZERO);
    assign mul10    = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + 36'(digit);
    assign ver_lane = 2'(r_offset - hrld_pkg::VER_FIRST);

    // Per-byte update
    always_comb begin
        n_recent       = r_recent;
        n_hdr_count    = r_hdr_count;
        n_key_pos      = r_key_pos;
        n_phase        = r_phase;
        n_accum        = r_accum;
        n_found        = r_found;
        n_header_done  = r_header_done;
        n_length_reg   = r_length_reg;
        n_offset       = r_offset;
        n_version      = r_version;
        n_error        = r_error;
        n_out_kind     = hrld_pkg::KIND_HEADER;
        n_out_byte     = 8'd0;
        n_out_offset   = 32'd0;
        n_out_length   = 32'd0;
        n_out_complete = 1'b0;
        len_val        = 32'd0;

        if (r_error) begin
            n_out_kind = hrld_pkg::KIND_IGNORED;
        end else if (!r_header_done) begin
            if (r_hdr_count >= CntW'(HEADER_MAX)) begin
                n_out_kind = hrld_pkg::KIND_OVERFLOW;
                n_error    = 1'b1;
            end else begin
                n_hdr_count = r_hdr_count + CntW'(1);
                // line scan for the length field
                if (b == hrld_pkg::CH_LF) begin
                    if (r_found) begin
                        n_phase = hrld_pkg::PH_REST;
                    end else begin
                        n_phase   = hrld_pkg::PH_KEY;
                        n_key_pos = '0;
                    end
                end else begin
                    case (r_phase)
                        hrld_pkg::PH_KEY: begin
                            if (r_key_pos < hrld_pkg::KEY_W'(hrld_pkg::NAME_LEN)) begin
                                if (lc == hrld_pkg::name_char(r_key_pos)) begin
                                    n_key_pos = r_key_pos + hrld_pkg::KEY_W'(1);
                                end else begin
                                    n_phase = hrld_pkg::PH_REST;
                                end
                            end else if (b == hrld_pkg::CH_COLON) begin
                                n_found = 1'b1;
                                n_accum = 32'd0;
                                n_phase = hrld_pkg::PH_BLANK;
                            end else begin
                                n_phase = hrld_pkg::PH_REST;
                            end
                        end
                        hrld_pkg::PH_BLANK, hrld_pkg::PH_DIGIT: begin
                            if (is_digit) begin
                                n_accum = (mul10[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                 : mul10[31:0];
                                n_phase = hrld_pkg::PH_DIGIT;
                            end else if (r_phase == hrld_pkg::PH_BLANK &&
                                         (b == hrld_pkg::CH_SPACE ||
                                          b == hrld_pkg::CH_TAB)) begin
                                n_phase = r_phase;
                            end else begin
                                n_phase = hrld_pkg::PH_REST;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
                // header terminator
                if (n_hdr_count >= CntW'(4) && r_recent == hrld_pkg::TERM_PREFIX &&
                    b == hrld_pkg::CH_LF) begin
                    len_val = n_found ? n_accum : 32'd0;
                    if (len_val == 32'd0 || len_val > r_max_length) begin
                        n_out_kind   = hrld_pkg::KIND_BAD_LEN;
                        n_error      = 1'b1;
                        n_out_length = len_val;
                    end else begin
                        n_length_reg  = len_val;
                        n_header_done = 1'b1;
                        n_hdr_count   = '0;
                    end
                end
                n_recent = {r_recent[15:0], b};
            end
        end else if (r_offset < r_length_reg) begin
            n_out_kind   = hrld_pkg::KIND_STORED;
            n_out_byte   = b;
            n_out_offset = r_offset;
            if (r_offset >= hrld_pkg::VER_FIRST && r_offset <= hrld_pkg::VER_LAST) begin
                case (ver_lane)
                    2'd0:    n_version[7:0]   = b;
                    2'd1:    n_version[15:8]  = b;
                    2'd2:    n_version[23:16] = b;
                    default: n_version[31:24] = b;
                endcase
            end
            n_out_complete = (r_offset + 32'd1 == r_length_reg);
            n_offset       = r_offset + 32'd1;
        end else begin
            n_out_kind = hrld_pkg::KIND_DROPPED;
        end

        if (n_header_done) begin
            n_out_length = n_length_reg;
        end
        n_out_vvalid  = (n_offset >= hrld_pkg::VER_DONE);
        n_out_version = n_out_vvalid ? n_version : 32'd0;
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_max_length  <= hrld_pkg::MAX_LENGTH_RESET;
            r_recent      <= '0;
            r_hdr_count   <= '0;
            r_key_pos     <= '0;
            r_phase       <= hrld_pkg::PH_KEY;
            r_accum       <= '0;
            r_found       <= 1'b0;
            r_header_done <= 1'b0;
            r_length_reg  <= '0;
            r_offset      <= '0;
            r_version     <= '0;
            r_error       <= 1'b0;
        end else begin
            // input stage
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            // result stage
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // configuration transaction
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_length <= i_cfg_data;
            end
            // state commit
            if (advance) begin
                r_recent      <= n_recent;
                r_hdr_count   <= n_hdr_count;
                r_key_pos     <= n_key_pos;
                r_phase       <= n_phase;
                r_accum       <= n_accum;
                r_found       <= n_found;
                r_header_done <= n_header_done;
                r_length_reg  <= n_length_reg;
                r_offset      <= n_offset;
                r_version     <= n_version;
                r_error       <= n_error;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
        if (advance) begin
            r_out_kind     <= n_out_kind;
            r_out_byte     <= n_out_byte;
            r_out_offset   <= n_out_offset;
            r_out_length   <= n_out_length;
            r_out_version  <= n_out_version;
            r_out_vvalid   <= n_out_vvalid;
            r_out_complete <= n_out_complete;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_kind            = r_out_kind;
    assign o_body_byte       = r_out_byte;
    assign o_body_offset     = r_out_offset;
    assign o_content_length  = r_out_length;
    assign o_package_version = r_out_version;
    assign o_version_valid   = r_out_vvalid;
    assign o_complete        = r_out_complete;

    // Checks
    `ASSERT_IMPLIES(a_offset_in_range, r_header_done, r_offset <= r_length_reg)
    `ASSERT_IMPLIES(a_error_before_body, r_error, !r_header_done)
    `ASSERT_IMPLIES(a_count_in_range, 1'b1, r_hdr_count <= CntW'(HEADER_MAX))
    `ASSERT_IMPLIES(a_complete_is_stored, r_out_complete, r_out_kind == hrld_pkg::KIND_STORED)
    `ASSERT_NEXT(a_result_follows, advance, r_out_valid)

endmodule

FILE: bench/http_response_length_deframer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_response_length_deframer_unit_tb
// Streams one HTTP response per run through the deframer: a short lead-in
// with extreme byte values and a near-miss header name, a randomly chosen
// header (good length, saturated length, rejected length, missing or empty
// length, zero limit, or an oversized header), then body or trailing bytes.
// Every accepted byte is run through a local model of the scanner and the
// expected per-byte report is checked against the result channel. The
// max_length register is rewritten between the three traffic phases.
// ----------------------------------------------------------------------------
module http_response_length_deframer_unit_tb;

    localparam int          HDR_LIMIT   = 512;
    localparam int          CYCLE_LIMIT = 200000;
    localparam string       NAME_TEXT   = "content-length";
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

    // One report per byte, laid out as on the result ports
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  body_byte;
        logic [31:0] offset;
        logic [31:0] length;
        logic [31:0] version;
        logic        ver_ok;
        logic        done;
    } t_byte_report;

    typedef enum int {
        SC_GOOD,
        SC_HUGE,
        SC_OVER_MAX,
        SC_NO_LENGTH,
        SC_ZERO_LENGTH,
        SC_MAX_ZERO,
        SC_OVERFLOW
    } t_scenario;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_body_byte;
    logic [31:0] o_body_offset;
    logic [31:0] o_content_length;
    logic [31:0] o_package_version;
    logic        o_version_valid;
    logic        o_complete;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = 32'h0;

    // Traffic control
    logic [7:0]   response_stream[$];
    logic [7:0]   response_tx_q[$];
    t_byte_report byte_reports_q[$];
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           mismatch_cnt  = 0;
    int           cycle_cnt     = 0;
    int           hdr_len       = 0;
    logic [31:0]  chosen_limit  = hrld_pkg::MAX_LENGTH_RESET;

    // Scanner model state
    logic [23:0]           scan_hist    = '0;
    int unsigned           hdr_cnt      = 0;
    int unsigned           key_pos      = 0;
    hrld_pkg::t_line_phase scan_phase   = hrld_pkg::PH_KEY;
    logic [31:0]           len_accum    = '0;
    logic                  len_seen     = 1'b0;
    logic                  hdr_closed   = 1'b0;
    logic [31:0]           body_len     = '0;
    logic [31:0]           body_off     = '0;
    logic [31:0]           version_word = '0;
    logic                  err_seen     = 1'b0;
    logic [31:0]           max_len      = hrld_pkg::MAX_LENGTH_RESET;

    http_response_length_deframer_unit #(
        .HEADER_MAX(HDR_LIMIT)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_kind            (o_kind),
        .o_body_byte       (o_body_byte),
        .o_body_offset     (o_body_offset),
        .o_content_length  (o_content_length),
        .o_package_version (o_package_version),
        .o_version_valid   (o_version_valid),
        .o_complete        (o_complete),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Model: advance the scanner by one byte and return its report
    function automatic t_byte_report deframe_byte(input logic [7:0] b);
        t_byte_report r;
        logic [35:0]  wide;
        logic [31:0]  len;
        logic [7:0]   lc;
        int           sh;
        r = '0;
        if (err_seen) begin
            r.kind = hrld_pkg::KIND_IGNORED;
        end else if (!hdr_closed) begin
            if (hdr_cnt >= HDR_LIMIT) begin
                r.kind   = hrld_pkg::KIND_OVERFLOW;
                err_seen = 1'b1;
            end else begin
                hdr_cnt++;
                // line scan: name match, blanks, digits, rest of line
                if (b == hrld_pkg::CH_LF) begin
                    if (len_seen) begin
                        scan_phase = hrld_pkg::PH_REST;
                    end else begin
                        scan_phase = hrld_pkg::PH_KEY;
                        key_pos    = 0;
                    end
                end else begin
                    case (scan_phase)
                        hrld_pkg::PH_KEY: begin
                            if (key_pos < hrld_pkg::NAME_LEN) begin
                                lc = (b >= hrld_pkg::CH_UC_A && b <= hrld_pkg::CH_UC_Z)
                                     ? b + 8'd32 : b;
                                if (lc == NAME_TEXT[key_pos]) key_pos++;
                                else scan_phase = hrld_pkg::PH_REST;
                            end else if (b == hrld_pkg::CH_COLON) begin
                                len_seen   = 1'b1;
                                len_accum  = '0;
                                scan_phase = hrld_pkg::PH_BLANK;
                            end else begin
                                scan_phase = hrld_pkg::PH_REST;
                            end
                        end
                        hrld_pkg::PH_BLANK, hrld_pkg::PH_DIGIT: begin
                            if (b >= hrld_pkg::CH_ZERO && b <= hrld_pkg::CH_NINE) begin
                                wide = {4'd0, len_accum} * 36'd10 +
                                       {28'd0, b - hrld_pkg::CH_ZERO};
                                len_accum  = (wide > {4'd0, ALL_ONES}) ? ALL_ONES : wide[31:0];
                                scan_phase = hrld_pkg::PH_DIGIT;
                            end else if (!(scan_phase == hrld_pkg::PH_BLANK &&
                                           (b == hrld_pkg::CH_SPACE ||
                                            b == hrld_pkg::CH_TAB))) begin
                                scan_phase = hrld_pkg::PH_REST;
                            end
                        end
                        default: ;
                    endcase
                end
                r.kind = hrld_pkg::KIND_HEADER;
                // blank line closes the header
                if (hdr_cnt >= 4 && scan_hist == hrld_pkg::TERM_PREFIX &&
                    b == hrld_pkg::CH_LF) begin
                    len = len_seen ? len_accum : 32'd0;
                    if (len == 32'd0 || len > max_len) begin
                        r.kind   = hrld_pkg::KIND_BAD_LEN;
                        r.length = len;
                        err_seen = 1'b1;
                    end else begin
                        body_len   = len;
                        hdr_closed = 1'b1;
                        hdr_cnt    = 0;
                    end
                end
                scan_hist = {scan_hist[15:0], b};
            end
        end else if (body_off < body_len) begin
            r.kind      = hrld_pkg::KIND_STORED;
            r.body_byte = b;
            r.offset    = body_off;
            if (body_off >= hrld_pkg::VER_FIRST && body_off <= hrld_pkg::VER_LAST) begin
                sh = int'(body_off[1:0]) * 8;
                version_word[sh +: 8] = b;
            end
            r.done = (body_off + 32'd1 == body_len);
            body_off++;
        end else begin
            r.kind = hrld_pkg::KIND_DROPPED;
        end
        if (hdr_closed) r.length = body_len;
        if (body_off >= hrld_pkg::VER_DONE) begin
            r.ver_ok  = 1'b1;
            r.version = version_word;
        end
        return r;
    endfunction

    function automatic string fmt_report(input t_byte_report r);
        return $sformatf("kind=%0d byte=%02h off=%0d len=%0d ver=%08h vv=%0b done=%0b",
                         r.kind, r.body_byte, r.offset, r.length, r.version,
                         r.ver_ok, r.done);
    endfunction

    // Stream builders
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == hrld_pkg::CH_CR || b == hrld_pkg::CH_LF);
        return b;
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) response_stream.push_back(s[i]);
    endtask

    task automatic add_crlf();
        response_stream.push_back(hrld_pkg::CH_CR);
        response_stream.push_back(hrld_pkg::CH_LF);
    endtask

    // First n characters of the header name, each letter in random case
    task automatic add_name(input int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            c = NAME_TEXT[i];
            if (c != "-" && $urandom_range(1) == 1) c = c - 8'd32;
            response_stream.push_back(c);
        end
    endtask

    task automatic add_noise_line();
        repeat ($urandom_range(1, 12)) response_stream.push_back(noise_byte());
        add_crlf();
    endtask

    // Header lines that must never set the length
    task automatic add_filler_line();
        case ($urandom_range(5))
            0, 1: add_noise_line();
            2: begin
                add_name($urandom_range(1, hrld_pkg::NAME_LEN - 1));
                response_stream.push_back(hrld_pkg::CH_COLON);
                add_text("12");
                add_crlf();
            end
            3: begin
                add_name(hrld_pkg::NAME_LEN);
                response_stream.push_back($urandom_range(1) ? hrld_pkg::CH_SPACE : "s");
                response_stream.push_back(hrld_pkg::CH_COLON);
                add_text("7");
                add_crlf();
            end
            4: begin
                // bare LF line ending
                repeat ($urandom_range(1, 8)) response_stream.push_back(noise_byte());
                response_stream.push_back(hrld_pkg::CH_LF);
            end
            default: begin
                // lone CR inside a line
                response_stream.push_back(noise_byte());
                response_stream.push_back(hrld_pkg::CH_CR);
                response_stream.push_back(noise_byte());
                add_crlf();
            end
        endcase
    endtask

    task automatic add_length_line(input string digits);
        add_name(hrld_pkg::NAME_LEN);
        response_stream.push_back(hrld_pkg::CH_COLON);
        repeat ($urandom_range(3))
            response_stream.push_back($urandom_range(1) ? hrld_pkg::CH_SPACE
                                                        : hrld_pkg::CH_TAB);
        add_text(digits);
        if ($urandom_range(2) == 0) add_text(" ;q");
        add_crlf();
    endtask

    // Configuration write; the model copy follows on the handshake
    task automatic write_max_length(input logic [31:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        max_len = v;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 32'($urandom());
    endtask

    // Inside the header keep the chosen limit, afterwards try the extremes
    task automatic retune_limit(input int cut);
        logic [31:0] v;
        if (cut < hdr_len) begin
            v = chosen_limit;
        end else begin
            case ($urandom_range(2))
                0:       v = ALL_ONES;
                1:       v = 32'd1;
                default: v = 32'd0;
            endcase
        end
        write_max_length(v);
    endtask

    task automatic feed_range(input int first, input int last);
        @(negedge i_clk);
        for (int i = first; i < last; i++) response_tx_q.push_back(response_stream[i]);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (response_tx_q.size() != 0 || i_in_valid || byte_reports_q.size() != 0);
    endtask

    // Byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                byte_reports_q.push_back(deframe_byte(i_data_byte));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (response_tx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid  <= 1'b1;
                    i_data_byte <= response_tx_q.pop_front();
                end else begin
                    i_in_valid  <= 1'b0;
                    i_data_byte <= 8'($urandom_range(255));
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        t_byte_report got;
        t_byte_report want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_kind, o_body_byte, o_body_offset, o_content_length,
                        o_package_version, o_version_valid, o_complete};
                if (byte_reports_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected transaction: %s", fmt_report(got));
                end else begin
                    want = byte_reports_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch at cycle %0d", cycle_cnt);
                            $display("  expected %s", fmt_report(want));
                            $display("  actual   %s", fmt_report(got));
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus and phase sequencing
    initial begin
        t_scenario   sc;
        logic [31:0] len_val;
        logic        write_first;
        int          pick;
        int          body_n;
        int          fill_to;
        int          n_total;
        int          cut1;
        int          cut2;
        string       digits;

        pick = $urandom_range(99);
        if (pick < 55)      sc = SC_GOOD;
        else if (pick < 65) sc = SC_HUGE;
        else if (pick < 73) sc = SC_OVER_MAX;
        else if (pick < 80) sc = SC_NO_LENGTH;
        else if (pick < 87) sc = SC_ZERO_LENGTH;
        else if (pick < 92) sc = SC_MAX_ZERO;
        else                sc = SC_OVERFLOW;

        write_first = 1'b1;
        body_n      = $urandom_range(250, 380);
        fill_to     = 0;
        len_val     = 32'd1;

        // lead-in: extreme byte values, then the full name with a blank before the colon
        response_stream.push_back(8'h00);
        response_stream.push_back(8'hFF);
        add_crlf();
        add_name(hrld_pkg::NAME_LEN);
        response_stream.push_back(hrld_pkg::CH_SPACE);
        response_stream.push_back(hrld_pkg::CH_COLON);
        add_text("7");
        add_crlf();
        repeat ($urandom_range(1, 5)) add_filler_line();

        // length value and limit for the chosen header
        case (sc)
            SC_GOOD: begin
                case ($urandom_range(5))
                    0, 1:    len_val = $urandom_range(1, 7);
                    2:       len_val = body_n;
                    3:       len_val = $urandom_range(body_n + 1, 1048576);
                    default: len_val = $urandom_range(8, body_n - 10);
                endcase
                case ($urandom_range(3))
                    0: chosen_limit = len_val;
                    1: chosen_limit = ALL_ONES;
                    2: chosen_limit = len_val + 32'($urandom_range(1, 1000));
                    default: write_first = 1'b0;
                endcase
                digits = $sformatf("%0d", len_val);
            end
            SC_HUGE, SC_OVER_MAX: begin
                chosen_limit = ALL_ONES;
                case ($urandom_range(2))
                    0: digits = "4294967295";
                    1: digits = "4294967296";
                    default: begin
                        digits = $sformatf("%0d", $urandom_range(1, 9));
                        repeat ($urandom_range(10, 13))
                            digits = $sformatf("%s%0d", digits, $urandom_range(9));
                    end
                endcase
                if (sc == SC_OVER_MAX) begin
                    if ($urandom_range(1) == 1) begin
                        chosen_limit = 32'hFFFF_FFFE;
                    end else begin
                        len_val      = $urandom_range(2, 100000);
                        chosen_limit = $urandom_range(1, len_val - 1);
                        digits       = $sformatf("%0d", len_val);
                    end
                end
            end
            SC_ZERO_LENGTH: begin
                chosen_limit = $urandom();
                case ($urandom_range(5))
                    0:       digits = "0";
                    1:       digits = "000";
                    2:       digits = "+12";
                    3:       digits = "-5";
                    4:       digits = "";
                    default: digits = "x7";
                endcase
            end
            SC_MAX_ZERO: begin
                chosen_limit = 32'd0;
                digits       = $sformatf("%0d", $urandom_range(1, 500));
            end
            default: begin
                chosen_limit = $urandom();
                digits       = $sformatf("%0d", $urandom_range(1, 300));
            end
        endcase
        if (sc == SC_GOOD || sc == SC_HUGE || sc == SC_OVER_MAX || sc == SC_MAX_ZERO)
            repeat ($urandom_range(2)) digits = {"0", digits};

        if (sc != SC_NO_LENGTH) add_length_line(digits);
        // a later length line must not override the first one
        if ($urandom_range(1) == 1) add_length_line("3");

        if (sc == SC_OVERFLOW) begin
            while (response_stream.size() < HDR_LIMIT + 24) add_filler_line();
            hdr_len = response_stream.size();
            body_n  = 40;
        end else begin
            if (sc == SC_GOOD || sc == SC_HUGE) begin
                repeat ($urandom_range(3)) add_filler_line();
            end else begin
                fill_to = $urandom_range(150, 440);
                while (response_stream.size() < fill_to) add_filler_line();
                body_n = 40;
            end
            add_noise_line();
            add_crlf();
            hdr_len = response_stream.size();
        end
        repeat (body_n) response_stream.push_back(8'($urandom_range(255)));

        n_total = response_stream.size();
        cut1    = n_total / 3;
        cut2    = (2 * n_total) / 3;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        if (write_first) write_max_length(chosen_limit);
        else chosen_limit = hrld_pkg::MAX_LENGTH_RESET;

        // phase one: sender idles lightly, receiver heavily
        send_idle_pct = 36;
        recv_idle_pct = 68;
        feed_range(0, cut1);
        wait_idle();
        retune_limit(cut1);

        // phase two: the other way round
        @(negedge i_clk);
        send_idle_pct = 68;
        recv_idle_pct = 36;
        feed_range(cut1, cut2);
        wait_idle();
        retune_limit(cut2);

        // phase three: full rate
        @(negedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        feed_range(cut2, n_total);
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/hrld_pkg.sv
sv/http_response_length_deframer_unit.sv
bench/http_response_length_deframer_unit_tb.sv
